// ===== rtl/source_address_block_list_assert.svh =====
// Assertion macros for the checker file of the block list.
`ifndef SOURCE_ADDRESS_BLOCK_LIST_ASSERT_SVH
`define SOURCE_ADDRESS_BLOCK_LIST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SABL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("block list assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SABL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("block list assertion failed");

`endif

// ===== rtl/sabl_pkg.sv =====
package sabl_pkg;

  localparam int ADDR_W = 32;
  localparam int USER_W = 32;

  typedef logic [1:0]        cmd_t;
  typedef logic [2:0]        status_t;
  typedef logic [4:0]        count_out_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [USER_W-1:0] user_t;

  localparam cmd_t CMD_CHECK  = 2'd0;
  localparam cmd_t CMD_ADD    = 2'd1;
  localparam cmd_t CMD_DELETE = 2'd2;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_DENIED    = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_DUPLICATE = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;

  localparam user_t ALLOWED_USER_RST = 32'd1000;

  // Register word index, taken from paddr[2].
  localparam logic REG_ALLOWED_USER = 1'b0;

  typedef struct packed {
    logic       drop;
    status_t    status;
    count_out_t entry_count;
  } res_t;

endpackage

// ===== rtl/sabl_mem.sv =====
module sabl_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output sabl_pkg::addr_t       rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  sabl_pkg::addr_t       wr_data
);

  sabl_pkg::addr_t mem [DEPTH];
  sabl_pkg::addr_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sabl_ctrl.sv =====
module sabl_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  sabl_pkg::cmd_t       cmd,
  input  sabl_pkg::addr_t      address,
  input  sabl_pkg::user_t      user,
  input  sabl_pkg::user_t      allowed_user,
  output logic                 busy,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  sabl_pkg::addr_t      rd_data,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output sabl_pkg::addr_t      wr_data,
  output logic                 res_valid,
  output sabl_pkg::res_t       res
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;

  localparam logic [CW-1:0] ONE      = CW'(1);
  localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       cmp_r, cmp_nxt;
  logic                vld_r, vld_nxt;
  logic                res_vld_r, res_vld_nxt;
  sabl_pkg::res_t      res_r, res_nxt;
  sabl_pkg::cmd_t      cmd_r;
  sabl_pkg::addr_t     addr_r;

  logic [CW-1:0]       last;
  logic [CW-1:0]       dst;
  logic                hit;
  logic                at_last;
  logic                miss;
  logic                accept;
  sabl_pkg::status_t   status_v;
  logic                drop_v;

  assign accept  = start && !busy;
  assign busy    = (state_r != S_IDLE);
  assign last    = count_r - ONE;
  assign dst     = cmp_r - ONE;
  assign hit     = vld_r && (rd_data == addr_r);
  assign at_last = vld_r && (cmp_r == last);
  // An empty table misses at once; otherwise the miss shows with the last entry.
  assign miss    = !hit && (at_last || (count_r == '0));

  // Reads always run ahead of the shift writes, so an entry is never read and
  // written back in overlapping cycles and no forwarding is needed.
  assign rd_en   = ((state_r == S_SEARCH) || (state_r == S_SHIFT)) && (idx_r < count_r);
  assign rd_addr = idx_r[AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = rd_en ? idx_r + ONE : idx_r;
    cmp_nxt     = idx_r;
    vld_nxt     = rd_en;
    res_vld_nxt = 1'b0;
    res_nxt     = res_r;
    status_v    = sabl_pkg::ST_OK;
    drop_v      = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = count_r[AW-1:0];
    wr_data     = addr_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          vld_nxt = 1'b0;
          if (cmd == sabl_pkg::CMD_CHECK) begin
            state_nxt = S_SEARCH;
          end else if (user != allowed_user) begin
            res_vld_nxt = 1'b1;
            status_v    = sabl_pkg::ST_DENIED;
          end else if (cmd == sabl_pkg::CMD_ADD) begin
            if (count_r >= DEPTH_CW) begin
              res_vld_nxt = 1'b1;
              status_v    = sabl_pkg::ST_FULL;
            end else begin
              state_nxt = S_SEARCH;
            end
          end else if (cmd == sabl_pkg::CMD_DELETE) begin
            state_nxt = S_SEARCH;
          end else begin
            // Unused command from the allowed user: no change, status ok.
            res_vld_nxt = 1'b1;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          case (cmd_r)
            sabl_pkg::CMD_CHECK: begin
              res_vld_nxt = 1'b1;
              drop_v      = 1'b1;
              state_nxt   = S_IDLE;
            end
            sabl_pkg::CMD_ADD: begin
              res_vld_nxt = 1'b1;
              status_v    = sabl_pkg::ST_DUPLICATE;
              state_nxt   = S_IDLE;
            end
            default: begin
              if (at_last) begin
                count_nxt   = last;
                res_vld_nxt = 1'b1;
                state_nxt   = S_IDLE;
              end else begin
                idx_nxt   = cmp_r + ONE;
                vld_nxt   = 1'b0;
                state_nxt = S_SHIFT;
              end
            end
          endcase
        end else if (miss) begin
          res_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
          case (cmd_r)
            sabl_pkg::CMD_CHECK: begin
              drop_v = 1'b0;
            end
            sabl_pkg::CMD_ADD: begin
              wr_en     = 1'b1;
              count_nxt = count_r + ONE;
            end
            default: begin
              status_v = sabl_pkg::ST_NOT_FOUND;
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (vld_r) begin
          wr_en   = 1'b1;
          wr_addr = dst[AW-1:0];
          wr_data = rd_data;
          if (at_last) begin
            count_nxt   = last;
            res_vld_nxt = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (res_vld_nxt) begin
      res_nxt.drop        = drop_v;
      res_nxt.status      = status_v;
      res_nxt.entry_count = sabl_pkg::count_out_t'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      idx_r     <= '0;
      cmp_r     <= '0;
      vld_r     <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      idx_r     <= idx_nxt;
      cmp_r     <= cmp_nxt;
      vld_r     <= vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (accept) begin
      cmd_r  <= cmd;
      addr_r <= address;
    end
  end

  assign res_valid = res_vld_r;
  assign res       = res_r;

endmodule

// ===== rtl/source_address_block_list.sv =====
// A refused item, a full table or an unused command is answered straight from idle; otherwise
// a search reads one table entry per cycle, and a delete that moves entries down
// restarts the reads at the entry after the hit before it shifts the rest down.
// Throughput: one item at a time; busy stays high while an item is searched or shifted.
// Reset (rst_n low, synchronous) empties the table and restores allowed_user to 1000.
// The result strobe lasts one cycle and the receiver cannot stall it.
module source_address_block_list #(
  parameter int DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  sabl_pkg::cmd_t         in_cmd,
  input  sabl_pkg::addr_t        in_address,
  input  sabl_pkg::user_t        in_user,
  output logic                   out_valid,
  output logic                   out_drop,
  output sabl_pkg::status_t      out_status,
  output sabl_pkg::count_out_t   out_entry_count,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sabl_pkg::user_t allowed_user_r;
  logic            reg_sel;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  sabl_pkg::addr_t rd_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  sabl_pkg::addr_t wr_data;
  sabl_pkg::res_t  res;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == sabl_pkg::REG_ALLOWED_USER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allowed_user_r <= sabl_pkg::ALLOWED_USER_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      allowed_user_r <= pwdata;
    end
  end

  assign prdata = reg_sel ? allowed_user_r : '0;

  sabl_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .cmd          (in_cmd),
    .address      (in_address),
    .user         (in_user),
    .allowed_user (allowed_user_r),
    .busy         (busy),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .res_valid    (out_valid),
    .res          (res)
  );

  sabl_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign out_drop        = res.drop;
  assign out_status      = res.status;
  assign out_entry_count = res.entry_count;

endmodule

// ===== rtl/sabl_checker.sv =====
`include "source_address_block_list_assert.svh"

module sabl_checker #(
  parameter int DEPTH = 16
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input logic                 out_drop,
  input sabl_pkg::status_t    out_status,
  input sabl_pkg::count_out_t out_entry_count
);

  // A transaction either answers at once or keeps the block busy until it does.
  `SABL_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, out_valid || busy)

  // The block only turns busy on an accepted transaction.
  `SABL_ASSERT_IMPL(a_busy_cause, clk, rst_n, $rose(busy), $past(start))

  // Results are delivered as the block goes idle, never while it still works.
  `SABL_ASSERT_IMPL(a_result_idle, clk, rst_n, out_valid, !busy)

  // A drop only comes from a successful check.
  `SABL_ASSERT_IMPL(a_drop_ok, clk, rst_n, out_valid && out_drop,
                    out_status == sabl_pkg::ST_OK)

  `SABL_ASSERT_IMPL(a_count_range, clk, rst_n, out_valid,
                    (DEPTH > 31) || (out_entry_count <= DEPTH))

endmodule

bind source_address_block_list sabl_checker #(
  .DEPTH (DEPTH)
) u_sabl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_drop        (out_drop),
  .out_status      (out_status),
  .out_entry_count (out_entry_count)
);

// ===== tb/sv/source_address_block_list_tb.sv =====
`timescale 1ns / 1ps

module source_address_block_list_tb;

  localparam int TABLE_DEPTH = 16;
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 145;
  localparam sabl_pkg::cmd_t CMD_RESERVED = 2'd3;
  localparam logic [2:0] ALLOWED_USER_ADDR = {sabl_pkg::REG_ALLOWED_USER, 2'b00};

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  sabl_pkg::cmd_t       in_cmd;
  sabl_pkg::addr_t      in_address;
  sabl_pkg::user_t      in_user;
  logic                 out_valid;
  logic                 out_drop;
  sabl_pkg::status_t    out_status;
  sabl_pkg::count_out_t out_entry_count;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  // Mirror of the block: the packed list of blocked addresses and the register.
  sabl_pkg::addr_t blocked_list[$];
  sabl_pkg::user_t allowed_user_mirror;
  sabl_pkg::res_t  expected_results[$];
  int    mismatch_count = 0;
  int    cycle_count = 0;
  bit    back_to_back = 1'b0;

  source_address_block_list #(.DEPTH(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_address(in_address),
    .in_user(in_user),
    .out_valid(out_valid),
    .out_drop(out_drop),
    .out_status(out_status),
    .out_entry_count(out_entry_count),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("source_address_block_list: mismatch");
      $finish;
    end
  end

  function automatic int find_blocked(sabl_pkg::addr_t a);
    foreach (blocked_list[i]) begin
      if (blocked_list[i] == a) return i;
    end
    return -1;
  endfunction

  // Works out the result of one transaction and applies it to the mirror.
  function automatic sabl_pkg::res_t filter_update(sabl_pkg::cmd_t c, sabl_pkg::addr_t a,
                                                   sabl_pkg::user_t u);
    sabl_pkg::res_t r;
    int   idx;
    r = '0;
    idx = find_blocked(a);
    if (c == sabl_pkg::CMD_CHECK) begin
      r.drop = (idx >= 0);
    end else if (u != allowed_user_mirror) begin
      r.status = sabl_pkg::ST_DENIED;
    end else if (c == sabl_pkg::CMD_ADD) begin
      // A full table wins over a duplicate.
      if (blocked_list.size() >= TABLE_DEPTH) r.status = sabl_pkg::ST_FULL;
      else if (idx >= 0) r.status = sabl_pkg::ST_DUPLICATE;
      else blocked_list.push_back(a);
    end else if (c == sabl_pkg::CMD_DELETE) begin
      if (idx < 0) r.status = sabl_pkg::ST_NOT_FOUND;
      else blocked_list.delete(idx);
    end
    r.entry_count = sabl_pkg::count_out_t'(blocked_list.size());
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (back_to_back) return 0;
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic sabl_pkg::cmd_t pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return sabl_pkg::CMD_CHECK;
    if (r < 70) return sabl_pkg::CMD_ADD;
    if (r < 94) return sabl_pkg::CMD_DELETE;
    return CMD_RESERVED;
  endfunction

  function automatic sabl_pkg::addr_t pick_address();
    int r;
    r = $urandom_range(0, 9);
    if (blocked_list.size() > 0 && r < 6)
      return blocked_list[$urandom_range(0, blocked_list.size() - 1)];
    return $urandom;
  endfunction

  function automatic sabl_pkg::user_t pick_user();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return allowed_user_mirror;
    if (r < 9) return $urandom;
    return allowed_user_mirror ^ (32'd1 << $urandom_range(0, 31));
  endfunction

  task automatic send_item(sabl_pkg::cmd_t c, sabl_pkg::addr_t a, sabl_pkg::user_t u);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      in_cmd <= sabl_pkg::cmd_t'($urandom);
      in_address <= $urandom;
      in_user <= $urandom;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_cmd <= c;
    in_address <= a;
    in_user <= u;
    do @(posedge clk); while (busy);
    expected_results.push_back(filter_update(c, a, u));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_access(logic write, logic [31:0] wdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= ALLOWED_USER_ADDR;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (write) begin
      allowed_user_mirror = wdata;
    end else if (prdata !== allowed_user_mirror) begin
      $display("%0t: allowed_user read expected %0h actual %0h",
               $time, allowed_user_mirror, prdata);
      mismatch_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  always @(posedge clk) begin
    sabl_pkg::res_t exp_res;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no transaction pending: drop %0d status %0d count %0d",
                 $time, out_drop, out_status, out_entry_count);
        mismatch_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_drop !== exp_res.drop) begin
          $display("%0t: drop expected %0d actual %0d", $time, exp_res.drop, out_drop);
          mismatch_count++;
        end
        if (out_status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status, out_status);
          mismatch_count++;
        end
        if (out_entry_count !== exp_res.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, exp_res.entry_count, out_entry_count);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_register_reset();
    cfg_access(1'b0, 32'd0);
  endtask

  task automatic test_directed_ops();
    send_item(sabl_pkg::CMD_CHECK, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(sabl_pkg::CMD_ADD, 32'h0000_0000, 32'd0);
    send_item(sabl_pkg::CMD_ADD, 32'h0000_0000, sabl_pkg::ALLOWED_USER_RST);
    send_item(sabl_pkg::CMD_ADD, 32'hFFFF_FFFF, sabl_pkg::ALLOWED_USER_RST);
    send_item(sabl_pkg::CMD_ADD, 32'h0000_0000, sabl_pkg::ALLOWED_USER_RST);
    send_item(sabl_pkg::CMD_CHECK, 32'h0000_0000, $urandom);
    send_item(sabl_pkg::CMD_CHECK, 32'hFFFF_FFFF, 32'd0);
    send_item(sabl_pkg::CMD_CHECK, 32'h1234_5678, sabl_pkg::ALLOWED_USER_RST);
    send_item(sabl_pkg::CMD_DELETE, 32'h1234_5678, sabl_pkg::ALLOWED_USER_RST);
    send_item(sabl_pkg::CMD_DELETE, 32'h0000_0000, sabl_pkg::ALLOWED_USER_RST + 32'd1);
    send_item(CMD_RESERVED, 32'h0000_0000, sabl_pkg::ALLOWED_USER_RST - 32'd1);
    send_item(CMD_RESERVED, 32'hFFFF_FFFF, sabl_pkg::ALLOWED_USER_RST);
    send_item(sabl_pkg::CMD_ADD, 32'hA5A5_A5A5, sabl_pkg::ALLOWED_USER_RST);
    send_item(sabl_pkg::CMD_ADD, 32'h5A5A_5A5A, sabl_pkg::ALLOWED_USER_RST);
    // Removing the first entry shifts the rest down.
    send_item(sabl_pkg::CMD_DELETE, 32'h0000_0000, sabl_pkg::ALLOWED_USER_RST);
    send_item(sabl_pkg::CMD_CHECK, 32'h0000_0000, sabl_pkg::ALLOWED_USER_RST);
    send_item(sabl_pkg::CMD_CHECK, 32'h5A5A_5A5A, sabl_pkg::ALLOWED_USER_RST);
    send_item(sabl_pkg::CMD_DELETE, 32'hFFFF_FFFF, sabl_pkg::ALLOWED_USER_RST);
    send_item(sabl_pkg::CMD_DELETE, 32'h5A5A_5A5A, sabl_pkg::ALLOWED_USER_RST);
    send_item(sabl_pkg::CMD_CHECK, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
    send_item(sabl_pkg::CMD_DELETE, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
  endtask

  task automatic test_fill_and_drain();
    sabl_pkg::addr_t a;
    while (blocked_list.size() < TABLE_DEPTH)
      send_item(sabl_pkg::CMD_ADD, $urandom, allowed_user_mirror);
    send_item(sabl_pkg::CMD_ADD, $urandom, allowed_user_mirror);
    a = blocked_list[$urandom_range(0, TABLE_DEPTH - 1)];
    send_item(sabl_pkg::CMD_ADD, a, allowed_user_mirror);
    send_item(sabl_pkg::CMD_CHECK, blocked_list[TABLE_DEPTH - 1], $urandom);
    send_item(sabl_pkg::CMD_DELETE, blocked_list[TABLE_DEPTH / 2], allowed_user_mirror);
    send_item(sabl_pkg::CMD_DELETE, blocked_list[blocked_list.size() - 1],
              allowed_user_mirror);
    send_item(sabl_pkg::CMD_CHECK, a, $urandom);
    while (blocked_list.size() > 0) begin
      a = blocked_list[$urandom_range(0, blocked_list.size() - 1)];
      send_item(sabl_pkg::CMD_DELETE, a, allowed_user_mirror);
      send_item(sabl_pkg::CMD_CHECK, a, $urandom);
    end
    send_item(sabl_pkg::CMD_DELETE, $urandom, allowed_user_mirror);
  endtask

  task automatic test_random_traffic(int n);
    sabl_pkg::cmd_t c;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) back_to_back = ($urandom_range(0, 3) == 0);
      c = pick_cmd();
      send_item(c, pick_address(), pick_user());
    end
    back_to_back = 1'b0;
  endtask

  task automatic test_permission_phase(sabl_pkg::user_t setting);
    wait_idle();
    cfg_access(1'b1, setting);
    cfg_access(1'b0, 32'd0);
    test_random_traffic(PHASE_ITEMS);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = sabl_pkg::CMD_CHECK;
    in_address = '0;
    in_user = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    allowed_user_mirror = sabl_pkg::ALLOWED_USER_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_reset();
    test_directed_ops();
    test_fill_and_drain();
    test_permission_phase(32'h0000_0000);
    test_permission_phase(32'hFFFF_FFFF);
    test_permission_phase($urandom);
    test_permission_phase(sabl_pkg::ALLOWED_USER_RST);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("source_address_block_list: match");
    end else begin
      $display("source_address_block_list: mismatch");
    end
    $finish;
  end

endmodule
